// ===== sv/spa_pkg.sv =====
// ============================================================================
// spa_pkg - shared types and constants for the scan pixel averaging block
// Field widths, register indexes, reset values and controller interface.
// ============================================================================
`default_nettype none

package spa_pkg;

	// field widths fixed by the interface
	localparam int SAMPLE_W    = 16;
	localparam int COORD_W     = 10;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 2;

	// fixed digitizer offset removed from every sample
	localparam int SAMPLE_OFFSET = 8000;

	// saturation limits of the pixel value
	localparam int PIX_MAX = 32767;
	localparam int PIX_MIN_MAG = 32768;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PIXELS_PER_LINE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LINES_PER_FRAME   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_PIXEL = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FLIP_ODD_LINES    = 2'd3;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] RST_PIXELS_PER_LINE   = 11'd512;
	localparam logic [CFG_DATA_W-1:0] RST_LINES_PER_FRAME   = 11'd512;
	localparam logic [CFG_DATA_W-1:0] RST_SAMPLES_PER_PIXEL = 11'd1;

	// controller to datapath
	typedef struct packed {
		logic accept;     // take the sample on the input this cycle
		logic start_div;  // hand the finished pixel sum to the divider
		logic load_out;   // move the quotient into the output register
	} spa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pixel_last; // next sample completes the current pixel
		logic div_busy;   // divider still iterating
		logic out_free;   // output register empty or being taken
	} spa_status_t;

endpackage

`default_nettype wire

// ===== sv/spa_divider.sv =====
// ============================================================================
// spa_divider - restoring unsigned divider, one quotient bit per cycle
// Divides an N-bit magnitude by a D-bit divisor.
// ============================================================================
`default_nettype none

module spa_divider #(
	parameter int N = 21,
	parameter int D = 5
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [N-1:0] dividend,
	input  wire logic [D-1:0] divisor,
	output logic              busy,
	output logic [N-1:0]      quotient
);

	localparam int CNT_W = $clog2(N + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D-1:0]     rem_q;
	logic [D-1:0]     div_q;
	logic [N-1:0]     quo_q;

	logic [D:0] trial;
	logic [D:0] diff;
	logic       ge;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[N-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(N);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CNT_W'(1));
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D-1:0] : trial[D-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== sv/spa_datapath.sv =====
// ============================================================================
// spa_datapath - configuration, accumulation, scan counters and output
// Sums offset-corrected samples, tracks line and column, divides and holds
// the finished pixel in the output register.
// ============================================================================
`default_nettype none

module spa_datapath
	import spa_pkg::*;
#(
	parameter int MAX_SPP = 16,
	parameter int MAX_PPL = 1024,
	parameter int MAX_LPF = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic signed [SAMPLE_W-1:0] raw_sample,
	input  wire logic                     out_stall,
	input  wire spa_cmd_t                 cmd,
	output spa_status_t                   status,
	output logic                          out_valid,
	output logic signed [SAMPLE_W-1:0]    pixel_value,
	output logic [COORD_W-1:0]            row,
	output logic [COORD_W-1:0]            column,
	output logic                          frame_end
);

	localparam int CW    = $clog2(MAX_SPP + 1);
	localparam int SUM_W = 17 + $clog2(MAX_SPP);
	localparam int PLW   = $clog2(MAX_PPL + 1);
	localparam int CLW   = $clog2(MAX_PPL);
	localparam int LLW   = $clog2(MAX_LPF + 1);
	localparam int LNW   = $clog2(MAX_LPF);

	function automatic int unsigned clamp_count(input logic [CFG_DATA_W-1:0] v,
	                                            input int unsigned maxv);
		int unsigned r;
		r = 32'(v);
		if (r == 0)
			r = 1;
		else if (r > maxv)
			r = maxv;
		return r;
	endfunction

	// configuration, held already clamped
	logic [PLW-1:0] ppl_q;
	logic [LLW-1:0] lpf_q;
	logic [CW-1:0]  spp_q;
	logic           flip_q;

	// running state
	logic [CW-1:0]           cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CLW-1:0]          col_q;
	logic [LNW-1:0]          line_q;

	// pixel waiting on the divider
	logic               neg_q;
	logic [COORD_W-1:0] pend_row_q;
	logic [COORD_W-1:0] pend_col_q;
	logic               pend_fe_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] pix_q;
	logic [COORD_W-1:0]         row_q;
	logic [COORD_W-1:0]         col_out_q;
	logic                       fe_q;

	logic signed [SUM_W-1:0] sample_corr;
	logic signed [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0]        sum_mag;
	logic [CW-1:0]           cnt_next;
	logic [PLW-1:0]          col_ext;
	logic [LLW-1:0]          line_ext;
	logic                    last_col;
	logic                    last_line;
	logic [PLW-1:0]          col_mir;
	logic                    div_busy;
	logic [SUM_W-1:0]        quo;
	logic signed [SAMPLE_W-1:0] pix_sat;

	assign sample_corr = SUM_W'(raw_sample) - SUM_W'(SAMPLE_OFFSET);
	assign sum_next    = sum_q + sample_corr;
	assign sum_mag     = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
	assign cnt_next    = cnt_q + CW'(1);

	assign col_ext   = PLW'(col_q);
	assign line_ext  = LLW'(line_q);
	assign last_col  = (col_ext + PLW'(1)) >= ppl_q;
	assign last_line = (line_ext + LLW'(1)) >= lpf_q;

	// mirror the columns of odd lines when flipping
	always_comb begin
		col_mir = col_ext;
		if (flip_q && line_q[0] && (col_ext < ppl_q))
			col_mir = ppl_q - PLW'(1) - col_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppl_q  <= PLW'(clamp_count(RST_PIXELS_PER_LINE, MAX_PPL));
			lpf_q  <= LLW'(clamp_count(RST_LINES_PER_FRAME, MAX_LPF));
			spp_q  <= CW'(clamp_count(RST_SAMPLES_PER_PIXEL, MAX_SPP));
			flip_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PIXELS_PER_LINE:   ppl_q  <= PLW'(clamp_count(cfg_data, MAX_PPL));
				REG_LINES_PER_FRAME:   lpf_q  <= LLW'(clamp_count(cfg_data, MAX_LPF));
				REG_SAMPLES_PER_PIXEL: spp_q  <= CW'(clamp_count(
				                                  CFG_DATA_W'(cfg_data[4:0]), MAX_SPP));
				REG_FLIP_ODD_LINES:    flip_q <= cfg_data[0];
				default:               flip_q <= flip_q;
			endcase
		end
	end

	// accumulate and advance the scan position; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			col_q  <= '0;
			line_q <= '0;
		end else if (cfg_write) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			col_q  <= '0;
			line_q <= '0;
		end else if (cmd.accept) begin
			if (cnt_next >= spp_q) begin
				cnt_q <= '0;
				sum_q <= '0;
				if (last_col) begin
					col_q  <= '0;
					line_q <= last_line ? '0 : line_q + LNW'(1);
				end else begin
					col_q <= col_q + CLW'(1);
				end
			end else begin
				cnt_q <= cnt_next;
				sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			neg_q      <= sum_next[SUM_W-1];
			pend_row_q <= COORD_W'(line_q);
			pend_col_q <= COORD_W'(col_mir);
			pend_fe_q  <= last_col && last_line;
		end
	end

	spa_divider #(
		.N (SUM_W),
		.D (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div),
		.dividend (sum_mag),
		.divisor  (spp_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	// restore the sign and saturate
	always_comb begin
		if (neg_q) begin
			if (quo > SUM_W'(PIX_MIN_MAG))
				pix_sat = SAMPLE_W'(-PIX_MIN_MAG);
			else
				pix_sat = -$signed(quo[SAMPLE_W-1:0]);
		end else begin
			if (quo > SUM_W'(PIX_MAX))
				pix_sat = SAMPLE_W'(PIX_MAX);
			else
				pix_sat = $signed(quo[SAMPLE_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pix_q     <= pix_sat;
			row_q     <= pend_row_q;
			col_out_q <= pend_col_q;
			fe_q      <= pend_fe_q;
		end
	end

	assign status.pixel_last = cnt_next >= spp_q;
	assign status.div_busy   = div_busy;
	assign status.out_free   = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign pixel_value = pix_q;
	assign row         = row_q;
	assign column      = col_out_q;
	assign frame_end   = fe_q;

endmodule

`default_nettype wire

// ===== sv/spa_ctrl.sv =====
// ============================================================================
// spa_ctrl - sequencer for sample intake, division and result hand-off
// Takes samples until a pixel completes, then holds the input while the
// divider runs and the result is moved to the output register.
// ============================================================================
`default_nettype none

module spa_ctrl
	import spa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire spa_status_t status,
	output logic             in_stall,
	output spa_cmd_t         cmd
);

	localparam logic [0:0] ST_ACC = 1'b0;
	localparam logic [0:0] ST_DIV = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_ACC: begin
				cmd.accept = in_valid;
				if (in_valid && status.pixel_last) begin
					cmd.start_div = 1'b1;
					state_next    = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!status.div_busy && status.out_free) begin
					cmd.load_out = 1'b1;
					state_next   = ST_ACC;
				end
			end
			default: state_next = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_ACC;
		else
			state_q <= state_next;
	end

	assign in_stall = (state_q != ST_ACC);

endmodule

`default_nettype wire

// ===== sv/scan_pixel_average_reorder_top.sv =====
// ============================================================================
// scan_pixel_average_reorder_top - bidirectional scan pixel averaging
// Averages offset-corrected digitizer samples per pixel and tags each pixel
// with its line and (optionally mirrored) column.
// ============================================================================
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  in       sink       in_valid / in_stall  raw_sample
//  out      source     out_valid/out_stall  pixel_value, row, column, frame_end
//  cfg      sink       cfg_write            cfg_index, cfg_data
//
//  The sample that completes a pixel starts the restoring divider, which
//  yields one quotient bit per cycle on a SUM_W-bit magnitude, where
//  SUM_W = 17 + clog2(MAX_SAMPLES_PER_PIXEL) (21 bits by default).
//  A finished pixel waits in the output register, and samples of the next
//  pixel are taken meanwhile; in_stall rises only while a division is
//  running or its result cannot yet be placed in the output register.
//  Reset restores the register defaults and starts a new frame; any
//  register write also starts a new frame. No memories, so no clearing pass.
//
`default_nettype none

module scan_pixel_average_reorder_top
	import spa_pkg::*;
#(
	parameter int MAX_SAMPLES_PER_PIXEL = 16,
	parameter int MAX_PIXELS_PER_LINE   = 1024,
	parameter int MAX_LINES_PER_FRAME   = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration
	input  wire logic                       cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	// sample request
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [SAMPLE_W-1:0] raw_sample,
	// pixel request
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [SAMPLE_W-1:0]      pixel_value,
	output logic [COORD_W-1:0]              row,
	output logic [COORD_W-1:0]              column,
	output logic                            frame_end
);

	spa_cmd_t    cmd;
	spa_status_t status;

	// sequence intake, division and hand-off
	spa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// hold configuration, sum samples, count the scan, divide and present
	spa_datapath #(
		.MAX_SPP (MAX_SAMPLES_PER_PIXEL),
		.MAX_PPL (MAX_PIXELS_PER_LINE),
		.MAX_LPF (MAX_LINES_PER_FRAME)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.raw_sample  (raw_sample),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.pixel_value (pixel_value),
		.row         (row),
		.column      (column),
		.frame_end   (frame_end)
	);

endmodule

`default_nettype wire

// ===== sv/spa_checker.sv =====
// ============================================================================
// spa_checker - port-level checks for the scan pixel averaging block
// Watches the pixel request stream and the configuration port.
// ============================================================================
`default_nettype none

module spa_checker
	import spa_pkg::*;
(
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       cfg_write,
	input wire logic [CFG_INDEX_W-1:0]     cfg_index,
	input wire logic [CFG_DATA_W-1:0]      cfg_data,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic signed [SAMPLE_W-1:0] raw_sample,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic signed [SAMPLE_W-1:0] pixel_value,
	input wire logic [COORD_W-1:0]         row,
	input wire logic [COORD_W-1:0]         column,
	input wire logic                       frame_end
);

	logic               out_take;
	logic               frame_start_q;
	logic [COORD_W-1:0] prev_row_q;

	assign out_take = out_valid && !out_stall;

	// note whether the next pixel opens a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
			prev_row_q    <= '0;
		end else if (cfg_write) begin
			frame_start_q <= 1'b1;
		end else if (out_take) begin
			frame_start_q <= frame_end;
			prev_row_q    <= row;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_value) && $stable(row)
		&& $stable(column) && $stable(frame_end))
		else $error("stalled pixel changed");

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_value <= 16'sd24767)
		else $error("pixel value above offset-corrected maximum");

	a_frame_start_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && frame_start_q |-> row == '0)
		else $error("first pixel of a frame not on line zero");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !frame_start_q |-> row == prev_row_q || row == prev_row_q + 10'd1)
		else $error("line index skipped within a frame");

endmodule

bind scan_pixel_average_reorder_top spa_checker u_spa_checker (.*);

`default_nettype wire
